// ----- sv/dbf_pkg.sv -----
// Shared constants and types for the delayed boxcar FIR filter.
`default_nettype none
package dbf_pkg;

  localparam int TAPS     = 64;
  localparam int GROUP    = 8;
  localparam int NGROUPS  = (TAPS + GROUP - 1) / GROUP;

  localparam int SAMPLE_W = 16;
  localparam int LAG_W    = 6;
  localparam int HW_W     = 4;
  localparam int GAIN_W   = 15;
  localparam int CFG_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W    = 21;
  localparam int FRAC_W   = 15;

  localparam int TAP_IDX_W = $clog2(TAPS);
  localparam int DW        = (TAP_IDX_W > LAG_W) ? TAP_IDX_W : LAG_W;
  localparam int CW        = DW + 1;
  localparam int GSW       = SAMPLE_W + $clog2(GROUP);
  localparam int SW        = SAMPLE_W + $clog2(TAPS);
  localparam int PW        = SW + GAIN_W + 1;

  localparam logic [LAG_W-1:0]  LAG_RST  = LAG_W'(0);
  localparam logic [HW_W-1:0]   HW_RST   = HW_W'(2);
  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(8192);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LAG_DELAY  = 2'd0,
    REG_HALF_WIDTH = 2'd1,
    REG_TAP_GAIN   = 2'd2
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [GSW-1:0]      gsum_t;

endpackage
`default_nettype wire

// ----- sv/delayed_boxcar_fir.sv -----
// Top level of the delayed boxcar FIR filter: tap line, windowed sum and gain.
// An accepted word passes the group sum, total sum and output registers before it is offered on the output.
// Throughput: one word per cycle; the three-stage pipeline only holds the input
// when every stage is full and the output word is stalled.
// Reset clears the tap history, empties the pipeline and restores the default
// lag, half width and tap gain.
`default_nettype none
module delayed_boxcar_fir (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [dbf_pkg::SAMPLE_W-1:0]   in_sample,
  input  wire logic                                  in_start_of_curve,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [dbf_pkg::OUT_W-1:0]           out_line_value,
  input  wire logic                                  cfg_we,
  input  wire logic [dbf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [dbf_pkg::CFG_W-1:0]             cfg_data
);

  logic [dbf_pkg::LAG_W-1:0]  lag_r;
  logic [dbf_pkg::HW_W-1:0]   hw_r;
  logic [dbf_pkg::GAIN_W-1:0] gain_r;

  dbf_pkg::sample_t hist_r   [dbf_pkg::TAPS];
  dbf_pkg::sample_t hist_nxt [dbf_pkg::TAPS];

  dbf_pkg::gsum_t gsum_r   [dbf_pkg::NGROUPS];
  dbf_pkg::gsum_t gsum_nxt [dbf_pkg::NGROUPS];

  logic signed [dbf_pkg::SW-1:0]    sum_r;
  logic signed [dbf_pkg::SW-1:0]    sum_nxt;
  logic signed [dbf_pkg::PW-1:0]    prod;
  logic signed [dbf_pkg::OUT_W-1:0] line_r;

  logic v1_r;
  logic v2_r;
  logic vo_r;
  logic in_acc;
  logic s2_ld;
  logic out_ld;

  logic [dbf_pkg::CW-1:0] lag_ext;
  logic [dbf_pkg::CW-1:0] hw_ext;

  // Handshake chain: each stage moves when the next one is empty or moving.
  assign out_ld   = v2_r && (!vo_r || !out_stall);
  assign s2_ld    = v1_r && (!v2_r || out_ld);
  assign in_stall = v1_r && !s2_ld;
  assign in_acc   = in_valid && !in_stall;

  assign out_valid      = vo_r;
  assign out_line_value = line_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r  <= dbf_pkg::LAG_RST;
      hw_r   <= dbf_pkg::HW_RST;
      gain_r <= dbf_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dbf_pkg::REG_LAG_DELAY:  lag_r  <= cfg_data[dbf_pkg::LAG_W-1:0];
        dbf_pkg::REG_HALF_WIDTH: hw_r   <= cfg_data[dbf_pkg::HW_W-1:0];
        dbf_pkg::REG_TAP_GAIN:   gain_r <= cfg_data[dbf_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // The tap line is zeroed at the start of a curve, so older samples drop out.
  always_comb begin
    for (int i = 0; i < dbf_pkg::TAPS; i++) begin
      if (in_start_of_curve) begin
        hist_nxt[i] = '0;
      end else if (i == 0) begin
        hist_nxt[i] = hist_r[0];
      end else begin
        hist_nxt[i] = hist_r[i-1];
      end
    end
    hist_nxt[0] = in_sample;
  end

  assign lag_ext = dbf_pkg::CW'(lag_r);
  assign hw_ext  = dbf_pkg::CW'(hw_r);

  always_comb begin
    for (int g = 0; g < dbf_pkg::NGROUPS; g++) begin
      gsum_nxt[g] = '0;
      for (int k = 0; k < dbf_pkg::GROUP; k++) begin
        if (g * dbf_pkg::GROUP + k < dbf_pkg::TAPS) begin
          if ((dbf_pkg::CW'(g * dbf_pkg::GROUP + k) + hw_ext >= lag_ext) &&
              (dbf_pkg::CW'(g * dbf_pkg::GROUP + k) <= lag_ext + hw_ext)) begin
            gsum_nxt[g] = gsum_nxt[g] +
                          dbf_pkg::GSW'(hist_nxt[g * dbf_pkg::GROUP + k]);
          end
        end
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < dbf_pkg::NGROUPS; g++) begin
      sum_nxt = sum_nxt + dbf_pkg::SW'(gsum_r[g]);
    end
  end

  // An arithmetic shift of the product rounds toward minus infinity.
  assign prod = dbf_pkg::PW'(sum_r) * $signed({1'b0, gain_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dbf_pkg::TAPS; i++) begin
        hist_r[i] <= '0;
      end
    end else if (in_acc) begin
      hist_r <= hist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (in_acc) begin
        v1_r <= 1'b1;
      end else if (s2_ld) begin
        v1_r <= 1'b0;
      end
      if (s2_ld) begin
        v2_r <= 1'b1;
      end else if (out_ld) begin
        v2_r <= 1'b0;
      end
      if (out_ld) begin
        vo_r <= 1'b1;
      end else if (!out_stall) begin
        vo_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      gsum_r <= gsum_nxt;
    end
    if (s2_ld) begin
      sum_r <= sum_nxt;
    end
    if (out_ld) begin
      line_r <= prod[dbf_pkg::FRAC_W +: dbf_pkg::OUT_W];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dbf_checker.sv -----
// Port checker for the delayed boxcar FIR filter and its bind to the top level.
`default_nettype none
module dbf_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_stall,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [dbf_pkg::OUT_W-1:0]    out_line_value
);

  // The input is held back only when the full pipeline backs up behind the output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output word was free");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word offered right after reset");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output word was dropped");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_line_value))
    else $error("stalled output word changed");

endmodule

bind delayed_boxcar_fir dbf_checker u_dbf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_line_value (out_line_value)
);
`default_nettype wire

// ----- verif/tb_delayed_boxcar_fir.sv -----
// Self-checking testbench for the delayed boxcar FIR filter with random handshakes and configs.
module tb_delayed_boxcar_fir;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [dbf_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    dbf_pkg::sample_t sample;
    logic             soc;
  } curve_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dbf_pkg::sample_t in_sample = '0;
  logic in_start_of_curve = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [dbf_pkg::OUT_W-1:0] out_line_value;
  logic cfg_we = 1'b0;
  logic [dbf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dbf_pkg::CFG_W-1:0] cfg_data = '0;

  curve_word_t pending_words[$];
  curve_word_t next_word;
  logic signed [dbf_pkg::OUT_W-1:0] line_fifo[$];
  logic signed [dbf_pkg::OUT_W-1:0] exp_line;

  // Shadow of the filter state and registers.
  dbf_pkg::sample_t taps_hist[dbf_pkg::TAPS];
  int curve_len = 0;
  logic [dbf_pkg::LAG_W-1:0] lag_q = dbf_pkg::LAG_RST;
  logic [dbf_pkg::HW_W-1:0] hw_q = dbf_pkg::HW_RST;
  logic [dbf_pkg::GAIN_W-1:0] gain_q = dbf_pkg::GAIN_RST;

  int fail_count = 0;
  int cycle_count = 0;
  int in_pct = 0;
  int out_pct = 0;
  int in_gap = 0;
  int out_gap = 0;
  int hold_left = 0;
  bit pressure_on = 1'b0;
  bit hold_done = 1'b0;

  delayed_boxcar_fir i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_start_of_curve (in_start_of_curve),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_line_value    (out_line_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [dbf_pkg::OUT_W-1:0] next_line(
    input dbf_pkg::sample_t s, input logic soc);
    int lo;
    int hi;
    longint acc;
    longint prod;
    if (soc) begin
      foreach (taps_hist[i]) taps_hist[i] = '0;
      curve_len = 0;
    end
    for (int i = dbf_pkg::TAPS - 1; i > 0; i--) taps_hist[i] = taps_hist[i-1];
    taps_hist[0] = s;
    if (curve_len < dbf_pkg::TAPS) curve_len++;
    lo = int'(lag_q) - int'(hw_q);
    hi = int'(lag_q) + int'(hw_q);
    if (lo < 0) lo = 0;
    if (hi > dbf_pkg::TAPS - 1) hi = dbf_pkg::TAPS - 1;
    acc = 0;
    for (int d = lo; d <= hi; d++) begin
      if (d < curve_len) acc += longint'(taps_hist[d]);
    end
    prod = acc * longint'(gain_q);
    return dbf_pkg::OUT_W'(prod >>> dbf_pkg::FRAC_W);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sender: one word per handshake, held steady while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        line_fifo.push_back(next_line(in_sample, in_start_of_curve));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0 && $urandom_range(0, 99) < in_pct) begin
          in_gap = $urandom_range(0, 6);
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_sample <= next_word.sample;
          in_start_of_curve <= next_word.soc;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each word against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (line_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected word: got %0d", out_line_value);
        end else begin
          exp_line = line_fifo.pop_front();
          if (out_line_value !== exp_line) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("line_value mismatch: expected %0d got %0d", exp_line, out_line_value);
            end
          end
        end
      end
      if (pressure_on && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (out_gap != 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < out_pct) begin
        out_gap = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_word(input dbf_pkg::sample_t s, input logic soc);
    curve_word_t w;
    w.sample = s;
    w.soc = soc;
    pending_words.push_back(w);
  endtask

  task automatic write_reg(input logic [dbf_pkg::CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= dbf_pkg::CFG_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      dbf_pkg::REG_LAG_DELAY:  lag_q = dbf_pkg::LAG_W'(value);
      dbf_pkg::REG_HALF_WIDTH: hw_q = dbf_pkg::HW_W'(value);
      dbf_pkg::REG_TAP_GAIN:   gain_q = dbf_pkg::GAIN_W'(value);
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || line_fifo.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic dbf_pkg::sample_t rand_sample();
    case ($urandom_range(0, 5))
      0: return dbf_pkg::sample_t'(16'h7FFF);
      1: return dbf_pkg::sample_t'(16'h8000);
      2: return dbf_pkg::sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return dbf_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Mostly whole curves of random length, with stray curve starts as noise.
  task automatic fill_curves(input int count);
    int n;
    int len;
    n = 0;
    while (n < count) begin
      len = $urandom_range(5, 150);
      add_word(rand_sample(), 1'b1);
      n++;
      for (int i = 1; i < len && n < count; i++) begin
        add_word(rand_sample(), $urandom_range(0, 49) == 0);
        n++;
      end
    end
  endtask

  task automatic random_config();
    int unsigned hw;
    int unsigned gain;
    case ($urandom_range(0, 3))
      0: write_reg(dbf_pkg::REG_LAG_DELAY, 0);
      1: write_reg(dbf_pkg::REG_LAG_DELAY, 63);
      default: write_reg(dbf_pkg::REG_LAG_DELAY, $urandom_range(0, 63));
    endcase
    case ($urandom_range(0, 7))
      0: hw = 0;
      1: hw = $urandom_range(9, 15);
      default: hw = $urandom_range(1, 8);
    endcase
    write_reg(dbf_pkg::REG_HALF_WIDTH, hw);
    case ($urandom_range(0, 4))
      0: gain = 0;
      1: gain = 32767;
      2, 3: gain = (hw == 0) ? 32767 : 16384 / hw;
      default: gain = $urandom_range(0, 32767);
    endcase
    write_reg(dbf_pkg::REG_TAP_GAIN, gain);
    if ($urandom_range(0, 2) == 0) write_reg(REG_SPARE, $urandom_range(0, 32767));
  endtask

  initial begin
    foreach (taps_hist[i]) taps_hist[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: sample extremes, alternating bits and a restart mid-stream.
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b1);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h0000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'hFFFF), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h0001), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h5555), 1'b0);
    add_word(dbf_pkg::sample_t'(16'hAAAA), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b1);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    drain();

    // Zero half width gives a single tap; full gain.
    write_reg(dbf_pkg::REG_HALF_WIDTH, 0);
    write_reg(dbf_pkg::REG_TAP_GAIN, 32767);
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b1);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b1);
    add_word(dbf_pkg::sample_t'(16'hFFFF), 1'b0);
    drain();

    // Window clipped at the top tap, widest half width, zero gain, spare index ignored.
    write_reg(dbf_pkg::REG_LAG_DELAY, 63);
    write_reg(dbf_pkg::REG_HALF_WIDTH, 15);
    write_reg(dbf_pkg::REG_TAP_GAIN, 0);
    write_reg(REG_SPARE, 32767);
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    drain();

    write_reg(dbf_pkg::REG_HALF_WIDTH, 8);
    write_reg(dbf_pkg::REG_TAP_GAIN, 32767);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h8000), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h7FFF), 1'b0);
    add_word(dbf_pkg::sample_t'(16'h0001), 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      if (ph == 2) begin
        in_pct = 0;
        out_pct = 0;
        pressure_on = 1'b1;
      end else if (ph >= 6) begin
        in_pct = 0;
        out_pct = 0;
      end else begin
        in_pct = $urandom_range(0, 3) * 10;
        out_pct = $urandom_range(0, 3) * 10;
      end
      fill_curves(131);
      drain();
      pressure_on = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
